### src/kfcv_pkg.sv
// kfcv_pkg: shared widths, register map, reset values and types for the
// constant-velocity kalman filter block. No dependencies.
package kfcv_pkg;

    localparam int DATA_W        = 32;
    localparam int VAR_W         = 31;
    localparam int FRAC_BITS_DEF = 16;
    // wide enough for any sum of a few 32-bit terms or a shifted 64-bit product
    localparam int SUM_W         = 66;
    localparam int PADDR_W       = 5;
    localparam int IDX_W         = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_INIT_POS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_INIT_VEL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_INIT_VAR  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MEAS_VAR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PROC_POS  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PROC_VEL  = 3'd5;

    localparam logic signed [DATA_W-1:0] INIT_POS_RST = 32'sd0;
    localparam logic signed [DATA_W-1:0] INIT_VEL_RST = 32'sd131072;
    localparam logic [VAR_W-1:0]         INIT_VAR_RST = 31'd65536;
    localparam logic [VAR_W-1:0]         MEAS_VAR_RST = 31'd65536;
    localparam logic [VAR_W-1:0]         PROC_POS_RST = 31'd0;
    localparam logic [VAR_W-1:0]         PROC_VEL_RST = 31'd0;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] init_pos;
        logic signed [DATA_W-1:0] init_vel;
        logic [VAR_W-1:0]         init_var;
        logic [VAR_W-1:0]         meas_var;
        logic [VAR_W-1:0]         proc_pos;
        logic [VAR_W-1:0]         proc_vel;
    } cfg_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    // saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DATA_W:0] upper;
        upper = v[SUM_W-1:DATA_W-1];
        if (upper == '0 || upper == '1) begin
            return v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            return DATA_MIN;
        end else begin
            return DATA_MAX;
        end
    endfunction

endpackage

### src/kfcv_div.sv
// kfcv_div: radix-2 restoring divider, (num * 2^FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits signed. Depends on kfcv_pkg.
module kfcv_div
    import kfcv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W:0]   den,
    output div_rsp_t                 rsp
);

    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int QW    = DATA_W + 1;
    localparam int CNT_W = $clog2(QW + 1);

    typedef enum logic {D_IDLE, D_RUN} div_state_t;

    div_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [QW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    work_reg, work_next;
    logic [QW-1:0]    den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [NW-1:0]    num_full;
    logic [NW-1:0]    num_mag;
    logic [QW-1:0]    den_mag;
    logic             ovf_start;
    logic [QW:0]      trial;
    logic             big;
    logic signed [DATA_W-1:0] quot;

    always_comb begin
        num_full  = {num, {FRAC_BITS{1'b0}}};
        num_mag   = num[DATA_W-1] ? (~num_full + NW'(1)) : num_full;
        den_mag   = den[QW-1] ? (~$unsigned(den) + QW'(1)) : $unsigned(den);
        // quotient of 2^QW or more: the top part alone already reaches the divisor
        ovf_start = QW'(num_mag[NW-1:QW]) >= den_mag;
        trial     = {rem_reg, work_reg[QW-1]} - {1'b0, den_reg};

        state_next = state_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        work_next  = work_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    rem_next  = QW'(num_mag[NW-1:QW]);
                    work_next = num_mag[QW-1:0];
                    den_next  = den_mag;
                    neg_next  = num[DATA_W-1] ^ den[QW-1];
                    ovf_next  = ovf_start;
                    cnt_next  = '0;
                    if (ovf_start) begin
                        done_next = 1'b1;
                    end else begin
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN: begin
                if (!trial[QW]) begin
                    rem_next  = trial[QW-1:0];
                    work_next = {work_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next  = {rem_reg[QW-2:0], work_reg[QW-1]};
                    work_next = {work_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        cnt_reg  <= cnt_next;
    end

    // sign and saturate the magnitude quotient
    always_comb begin
        big = ovf_reg || work_reg[QW-1] || work_reg[DATA_W-1];
        if (neg_reg) begin
            quot = big ? DATA_MIN : $signed(~work_reg[DATA_W-1:0] + DATA_W'(1));
        end else begin
            quot = big ? DATA_MAX : $signed(work_reg[DATA_W-1:0]);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot;

endmodule

### src/kfcv_core.sv
// kfcv_core: filter state, step sequencer and the shared multiply and
// saturating add unit; uses kfcv_div for the two gains. Depends on kfcv_pkg.
module kfcv_core
    import kfcv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] in_meas,
    input  logic                     in_restart,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic signed [DATA_W-1:0] res_pos,
    output logic signed [DATA_W-1:0] res_vel
);

    typedef enum logic [2:0] {
        C_IDLE, C_PRED, C_INNOV, C_DIV0, C_DIV1, C_MUL, C_ACC, C_DONE
    } core_state_t;

    localparam logic [2:0] STEP_POS  = 3'd0;
    localparam logic [2:0] STEP_VEL  = 3'd1;
    localparam logic [2:0] STEP_VPOS = 3'd2;
    localparam logic [2:0] STEP_COV  = 3'd3;
    localparam logic [2:0] STEP_VVEL = 3'd4;

    core_state_t state_reg;
    logic [2:0]  step_reg;

    // filter state
    logic signed [DATA_W-1:0] pos_reg, vel_reg, vpos_reg, cov_reg, vvel_reg;
    // per-item working values
    logic signed [DATA_W-1:0] meas_reg, p_reg, a_reg, b_reg, d_reg, y_reg;
    logic signed [DATA_W-1:0] k0_reg, k1_reg;
    logic signed [DATA_W:0]   s_reg;
    logic signed [2*DATA_W-1:0] prod_reg;

    logic signed [DATA_W-1:0] p_pred, a_pred, b_pred, d_pred, y_comb;
    logic signed [DATA_W:0]   s_comb;
    logic signed [DATA_W-1:0] op_a, op_b, acc_base, acc_res;
    logic signed [2*DATA_W-1:0] mul_out;
    logic signed [SUM_W-1:0]  term_ext, acc_sum;

    logic                     div_start;
    logic signed [DATA_W-1:0] div_num;
    logic signed [DATA_W:0]   div_den;
    div_rsp_t                 div_rsp;

    kfcv_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .rsp     (div_rsp)
    );

    // predict and innovation
    always_comb begin
        p_pred = sat_data(SUM_W'(pos_reg) + SUM_W'(vel_reg));
        a_pred = sat_data(SUM_W'(vpos_reg) + (SUM_W'(cov_reg) <<< 1) + SUM_W'(vvel_reg)
                          + SUM_W'($signed({1'b0, cfg.proc_pos})));
        b_pred = sat_data(SUM_W'(cov_reg) + SUM_W'(vvel_reg));
        d_pred = sat_data(SUM_W'(vvel_reg) + SUM_W'($signed({1'b0, cfg.proc_vel})));
        y_comb = sat_data(SUM_W'(meas_reg) - SUM_W'(p_reg));
        s_comb = (DATA_W + 1)'(a_reg) + (DATA_W + 1)'($signed({2'b00, cfg.meas_var}));
    end

    assign div_start = (state_reg == C_INNOV && s_comb != '0) ||
                       (state_reg == C_DIV0 && div_rsp.done);
    assign div_num   = (state_reg == C_INNOV) ? a_reg : b_reg;
    assign div_den   = (state_reg == C_INNOV) ? s_comb : s_reg;

    // shared multiply and accumulate unit, operands picked by the update step
    always_comb begin
        op_a     = k0_reg;
        op_b     = y_reg;
        acc_base = p_reg;
        case (step_reg)
            STEP_POS: begin
                op_a = k0_reg; op_b = y_reg; acc_base = p_reg;
            end
            STEP_VEL: begin
                op_a = k1_reg; op_b = y_reg; acc_base = vel_reg;
            end
            STEP_VPOS: begin
                op_a = k0_reg; op_b = a_reg; acc_base = a_reg;
            end
            STEP_COV: begin
                op_a = k0_reg; op_b = b_reg; acc_base = b_reg;
            end
            STEP_VVEL: begin
                op_a = k1_reg; op_b = b_reg; acc_base = d_reg;
            end
            default: begin
                op_a = k0_reg; op_b = y_reg; acc_base = p_reg;
            end
        endcase
        mul_out  = op_a * op_b;
        term_ext = SUM_W'(prod_reg >>> FRAC_BITS);
        // state estimates add the correction, covariance entries subtract it
        if (step_reg == STEP_POS || step_reg == STEP_VEL) begin
            acc_sum = SUM_W'(acc_base) + term_ext;
        end else begin
            acc_sum = SUM_W'(acc_base) - term_ext;
        end
        acc_res = sat_data(acc_sum);
    end

    assign in_ready  = (state_reg == C_IDLE);
    assign res_valid = (state_reg == C_DONE);
    assign res_pos   = pos_reg;
    assign res_vel   = vel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            step_reg  <= STEP_POS;
            pos_reg   <= INIT_POS_RST;
            vel_reg   <= INIT_VEL_RST;
            vpos_reg  <= $signed({1'b0, INIT_VAR_RST});
            cov_reg   <= '0;
            vvel_reg  <= $signed({1'b0, INIT_VAR_RST});
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (in_valid) begin
                        if (in_restart) begin
                            pos_reg  <= cfg.init_pos;
                            vel_reg  <= cfg.init_vel;
                            vpos_reg <= $signed({1'b0, cfg.init_var});
                            cov_reg  <= '0;
                            vvel_reg <= $signed({1'b0, cfg.init_var});
                        end
                        state_reg <= C_PRED;
                    end
                end
                C_PRED: begin
                    state_reg <= C_INNOV;
                end
                C_INNOV: begin
                    if (s_comb == '0) begin
                        // zero divisor: keep the prediction
                        pos_reg   <= p_reg;
                        vpos_reg  <= a_reg;
                        cov_reg   <= b_reg;
                        vvel_reg  <= d_reg;
                        state_reg <= C_DONE;
                    end else begin
                        state_reg <= C_DIV0;
                    end
                end
                C_DIV0: begin
                    if (div_rsp.done) begin
                        state_reg <= C_DIV1;
                    end
                end
                C_DIV1: begin
                    if (div_rsp.done) begin
                        step_reg  <= STEP_POS;
                        state_reg <= C_MUL;
                    end
                end
                C_MUL: begin
                    state_reg <= C_ACC;
                end
                C_ACC: begin
                    case (step_reg)
                        STEP_POS:  pos_reg  <= acc_res;
                        STEP_VEL:  vel_reg  <= acc_res;
                        STEP_VPOS: vpos_reg <= acc_res;
                        STEP_COV:  cov_reg  <= acc_res;
                        STEP_VVEL: vvel_reg <= acc_res;
                        default: begin
                        end
                    endcase
                    if (step_reg == STEP_VVEL) begin
                        state_reg <= C_DONE;
                    end else begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= C_MUL;
                    end
                end
                C_DONE: begin
                    if (res_ready) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                meas_reg <= in_meas;
            end
            C_PRED: begin
                p_reg <= p_pred;
                a_reg <= a_pred;
                b_reg <= b_pred;
                d_reg <= d_pred;
            end
            C_INNOV: begin
                y_reg <= y_comb;
                s_reg <= s_comb;
            end
            C_DIV0: begin
                if (div_rsp.done) begin
                    k0_reg <= div_rsp.quot;
                end
            end
            C_DIV1: begin
                if (div_rsp.done) begin
                    k1_reg <= div_rsp.quot;
                end
            end
            C_MUL: begin
                prod_reg <= mul_out;
            end
            default: begin
            end
        endcase
    end

endmodule

### src/kalman_filter_const_velocity_unit.sv
// channel  | dir | signals                                   | item
// ---------+-----+-------------------------------------------+------------------------------
// s_       | in  | s_tvalid s_tready s_tdata[31:0] s_tuser   | measurement, restart flag
// m_       | out | m_tvalid m_tready m_tdata[63:0]           | est_position, est_velocity
// apb      | in  | psel penable pwrite paddr pwdata prdata   | six filter setup registers
//
// from one accept to the next an item goes through predict, innovation, two gain
// divisions in the shared radix-2 divider (ending early when the gain saturates),
// five multiply and accumulate steps (a multiply and an accumulate state each) and
// a done state; with a zero divisor the divisions and updates are skipped
// s_tready is high only while the sequencer is idle; a finished item sits in the
// output register, so the next item is taken while it waits for m_tready
// aresetn is synchronous, active low; state reloads from the reset register values
// Top level of the constant-velocity kalman filter; depends on kfcv_pkg and
// kfcv_core (which holds kfcv_div).
module kalman_filter_const_velocity_unit
    import kfcv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [31:0] measurement
    input  logic [0:0]            s_tuser,   // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,   // [31:0] est_position, [63:32] est_velocity
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    cfg_t                     cfg_reg;
    logic [IDX_W-1:0]         reg_idx;
    logic                     cfg_wr;

    logic                     core_res_valid;
    logic                     core_res_ready;
    logic signed [DATA_W-1:0] core_pos;
    logic signed [DATA_W-1:0] core_vel;

    logic                     m_tvalid_reg;
    logic [2*DATA_W-1:0]      m_tdata_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.init_pos <= INIT_POS_RST;
            cfg_reg.init_vel <= INIT_VEL_RST;
            cfg_reg.init_var <= INIT_VAR_RST;
            cfg_reg.meas_var <= MEAS_VAR_RST;
            cfg_reg.proc_pos <= PROC_POS_RST;
            cfg_reg.proc_vel <= PROC_VEL_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_INIT_POS: cfg_reg.init_pos <= $signed(pwdata);
                REG_INIT_VEL: cfg_reg.init_vel <= $signed(pwdata);
                REG_INIT_VAR: cfg_reg.init_var <= pwdata[VAR_W-1:0];
                REG_MEAS_VAR: cfg_reg.meas_var <= pwdata[VAR_W-1:0];
                REG_PROC_POS: cfg_reg.proc_pos <= pwdata[VAR_W-1:0];
                REG_PROC_VEL: cfg_reg.proc_vel <= pwdata[VAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INIT_POS: prdata = cfg_reg.init_pos;
            REG_INIT_VEL: prdata = cfg_reg.init_vel;
            REG_INIT_VAR: prdata = {1'b0, cfg_reg.init_var};
            REG_MEAS_VAR: prdata = {1'b0, cfg_reg.meas_var};
            REG_PROC_POS: prdata = {1'b0, cfg_reg.proc_pos};
            REG_PROC_VEL: prdata = {1'b0, cfg_reg.proc_vel};
            default:      prdata = '0;
        endcase
    end

    kfcv_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_meas    ($signed(s_tdata)),
        .in_restart (s_tuser[0]),
        .res_valid  (core_res_valid),
        .res_ready  (core_res_ready),
        .res_pos    (core_pos),
        .res_vel    (core_vel)
    );

    // output register parts the sequencer from the result channel
    assign core_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (core_res_ready) begin
            m_tvalid_reg <= core_res_valid;
        end
        if (core_res_valid && core_res_ready) begin
            m_tdata_reg <= {core_vel, core_pos};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // an accepted item keeps the sequencer busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sequencer ready right after accepting an item");

    // a finished item is never offered while the sequencer is open for input
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_res_valid |-> !s_tready)
        else $error("result pending while input is ready");

    // a result handed to the output register shows up on the result channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_res_valid && core_res_ready |=> m_tvalid && m_tdata == $past({core_vel, core_pos}))
        else $error("result lost on its way to the output register");
`endif

endmodule
